[hw/rtl/vta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vta_pkg: shared definitions for the Viterbi trellis ACS block
// Function codes, register indexes, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package vta_pkg;

	localparam int MAX_STATES = 32;

	localparam int FUNC_W  = 2;
	localparam int STATE_W = 5;
	localparam int SCORE_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TRANS = 2'd0,
		FUNC_INIT  = 2'd1,
		FUNC_EMIT  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_USE_LOG    = 2'd0,
		REG_FORCED     = 2'd1,
		REG_STATES     = 2'd2,
		REG_NONE       = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAITC,
		ST_FINAL
	} state_t;

endpackage

[hw/rtl/vta_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vta_if: channel interfaces of the Viterbi trellis ACS block
// Input item, result and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface vta_in_if;
	logic                               valid;
	logic                               ready;
	logic [vta_pkg::FUNC_W-1:0]         func;
	logic [vta_pkg::STATE_W-1:0]        from_state;
	logic [vta_pkg::STATE_W-1:0]        to_state;
	logic signed [vta_pkg::SCORE_W-1:0] value;
	logic                               first_obs;

	modport source (output valid, func, from_state, to_state, value, first_obs,
		input ready);
	modport sink (input valid, func, from_state, to_state, value, first_obs,
		output ready);
endinterface

interface vta_out_if;
	logic                               valid;
	logic                               ready;
	logic [vta_pkg::STATE_W-1:0]        state_index;
	logic signed [vta_pkg::SCORE_W-1:0] path_score;
	logic [vta_pkg::STATE_W-1:0]        best_predecessor;
	logic                               last_of_column;

	modport source (output valid, state_index, path_score, best_predecessor,
		last_of_column, input ready);
	modport sink (input valid, state_index, path_score, best_predecessor,
		last_of_column, output ready);
endinterface

interface vta_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [vta_pkg::CFG_IDX_W-1:0]  index;
	logic [vta_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/viterbi_trellis_acs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// viterbi_trellis_acs: forward-pass add-compare-select of an HMM Viterbi
// Transition, initial and score tables in synchronous RAMs; one ACS unit.
// ----------------------------------------------------------------------------
// Usage:
//   item   : loader words (transition, initial entry) and emission words,
//            emissions given per column in state order.
//   result : one word per emission for a state in use: score, predecessor,
//            last-of-column flag. Loads and unused codes give nothing.
//   cfg    : register writes, only while the block is idle.
// Timing: an emission scans its predecessors one per cycle through the
//   transition and score RAM read ports, all states in use or at most three
//   predecessors under forced alignment; a first-column emission reads the
//   initial table instead and scans none.
// The result sits in an output register; the next word is taken while it
//   waits. If the receiver still stalls when the next result is due, the
//   final ACS stage holds until the register frees.
// Reset clears the sequencer, valid flags and bank select and presets the
//   configuration registers; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module viterbi_trellis_acs (
	input  logic       clk,
	input  logic       arst_n,
	vta_in_if.sink     item,
	vta_out_if.source  result,
	vta_cfg_if.sink    cfg
);

	localparam int MAX_STATES = vta_pkg::MAX_STATES;
	localparam int SW = $clog2(MAX_STATES);
	localparam int NW = $clog2(MAX_STATES + 1);
	localparam int CW = (NW > vta_pkg::CFG_DAT_W) ? NW : vta_pkg::CFG_DAT_W;
	localparam int TW = $clog2(MAX_STATES * MAX_STATES);
	localparam int BW = $clog2(2 * MAX_STATES);
	localparam int DW = vta_pkg::SCORE_W;
	localparam int XW = vta_pkg::STATE_W;

	// configuration
	logic                          use_log_q;
	logic                          forced_q;
	logic [vta_pkg::CFG_DAT_W-1:0] states_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_log_q <= 1'b1;
			forced_q  <= 1'b0;
			states_q  <= vta_pkg::CFG_DAT_W'(32);
		end else if (cfg.valid) begin
			unique case (vta_pkg::cfg_reg_t'(cfg.index))
				vta_pkg::REG_USE_LOG: use_log_q <= cfg.data[0];
				vta_pkg::REG_FORCED:  forced_q  <= cfg.data[0];
				vta_pkg::REG_STATES:  states_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// memories
	logic signed [DW-1:0] tr_mem [MAX_STATES*MAX_STATES];
	logic signed [DW-1:0] in_mem [MAX_STATES];
	logic signed [DW-1:0] sc_mem [2*MAX_STATES];
	logic signed [DW-1:0] tr_rd, in_rd, sc_rd;

	vta_pkg::state_t state_q, state_d;

	logic [CW-1:0] su, n_eff, to_w, lo_in, hi_in;
	logic          acc, emit_go, is_load_tr, is_load_in;
	logic          rd_issue, fin_issue, last_cand, fin_done, stall;
	logic [CW-1:0] rd_k;
	logic [XW-1:0] rd_to;

	logic [XW-1:0]        to_q;
	logic signed [DW-1:0] value_q;
	logic                 first_q;
	logic [CW-1:0]        lo_q, hi_q, k_q, bk_q;
	logic signed [DW-1:0] best_q;
	logic                 bank_q;

	logic                 v_s1, fin_s1;
	logic [CW-1:0]        k_s1;
	logic                 v_s2, fin_s2;
	logic [CW-1:0]        k_s2;
	logic signed [63:0]   p_s2;

	logic signed [DW-1:0] a_in, b_in, c_s3;
	logic signed [63:0]   p_in, q_s3;

	logic                 out_valid_q;
	logic [XW-1:0]        out_idx_q, out_bp_q;
	logic signed [DW-1:0] out_score_q;
	logic                 out_last_q;

	assign su    = CW'(states_q);
	assign n_eff = (su == '0) ? CW'(1) : ((su > CW'(MAX_STATES)) ? CW'(MAX_STATES) : su);
	assign to_w  = CW'(item.to_state);
	assign lo_in = forced_q ? ((to_w >= CW'(2)) ? to_w - CW'(2) : '0) : '0;
	assign hi_in = forced_q ? to_w : n_eff - CW'(1);

	assign item.ready = (state_q == vta_pkg::ST_IDLE);
	assign acc        = item.valid && item.ready;
	assign emit_go    = acc && (vta_pkg::func_t'(item.func) == vta_pkg::FUNC_EMIT)
		&& (to_w < n_eff);
	assign is_load_tr = acc && (vta_pkg::func_t'(item.func) == vta_pkg::FUNC_TRANS)
		&& (32'(item.from_state) < MAX_STATES) && (32'(item.to_state) < MAX_STATES);
	assign is_load_in = acc && (vta_pkg::func_t'(item.func) == vta_pkg::FUNC_INIT)
		&& (32'(item.to_state) < MAX_STATES);

	assign stall     = fin_s2 && out_valid_q && !result.ready;
	assign last_cand = v_s2 && !fin_s2 && (k_s2 == hi_q);
	assign fin_done  = fin_s2 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= vta_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		rd_issue  = 1'b0;
		fin_issue = 1'b0;
		rd_k      = k_q;
		rd_to     = to_q;
		unique case (state_q)
			vta_pkg::ST_IDLE: begin
				rd_k  = lo_in;
				rd_to = item.to_state;
				if (emit_go) begin
					if (item.first_obs) begin
						fin_issue = 1'b1;
						state_d   = vta_pkg::ST_FINAL;
					end else begin
						rd_issue = 1'b1;
						state_d  = (lo_in == hi_in) ? vta_pkg::ST_WAITC : vta_pkg::ST_SCAN;
					end
				end
			end
			vta_pkg::ST_SCAN: begin
				rd_issue = 1'b1;
				if (k_q == hi_q) state_d = vta_pkg::ST_WAITC;
			end
			vta_pkg::ST_WAITC: begin
				if (last_cand) begin
					fin_issue = 1'b1;
					state_d   = vta_pkg::ST_FINAL;
				end
			end
			vta_pkg::ST_FINAL: begin
				if (fin_done) state_d = vta_pkg::ST_IDLE;
			end
			default: state_d = vta_pkg::ST_IDLE;
		endcase
	end

	// RAM ports: read data registered
	always_ff @(posedge clk) begin
		if (is_load_tr)
			tr_mem[TW'(item.from_state) * TW'(MAX_STATES) + TW'(item.to_state)] <= item.value;
		tr_rd <= tr_mem[TW'(rd_k[SW-1:0]) * TW'(MAX_STATES) + TW'(rd_to)];
	end

	always_ff @(posedge clk) begin
		if (is_load_in)
			in_mem[SW'(item.to_state)] <= item.value;
		in_rd <= in_mem[SW'(item.to_state)];
	end

	always_ff @(posedge clk) begin
		if (fin_done)
			sc_mem[BW'(bank_q) * BW'(MAX_STATES) + BW'(to_q)] <= c_s3;
		sc_rd <= sc_mem[{~bank_q, rd_k[SW-1:0]}];
	end

	// ACS datapath
	always_comb begin
		a_in = fin_s1 ? (first_q ? in_rd : best_q) : sc_rd;
		b_in = fin_s1 ? value_q : tr_rd;
		if (use_log_q) p_in = 64'(a_in) + 64'(b_in);
		else           p_in = a_in * b_in + 64'sd536870912;
		q_s3 = use_log_q ? p_s2 : (p_s2 >>> 30);
		if (q_s3 > 64'sd2147483647)       c_s3 = 32'sh7FFFFFFF;
		else if (q_s3 < -64'sd2147483648) c_s3 = 32'sh80000000;
		else                              c_s3 = q_s3[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			fin_s1      <= 1'b0;
			v_s2        <= 1'b0;
			fin_s2      <= 1'b0;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1   <= rd_issue;
			fin_s1 <= fin_issue;
			if (!stall) begin
				v_s2   <= v_s1;
				fin_s2 <= fin_s1;
			end
			if (result.valid && result.ready) out_valid_q <= 1'b0;
			if (fin_done) begin
				out_valid_q <= 1'b1;
				if (CW'(to_q) == n_eff - CW'(1)) bank_q <= ~bank_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= rd_k;
		if (!stall) begin
			k_s2 <= k_s1;
			p_s2 <= p_in;
		end
		if (rd_issue) k_q <= rd_k + CW'(1);
		if (acc) begin
			to_q    <= item.to_state;
			value_q <= item.value;
			first_q <= item.first_obs;
			lo_q    <= lo_in;
			hi_q    <= hi_in;
		end
		// lowest index wins ties: strict compare after the first candidate
		if (v_s2 && !fin_s2 && ((k_s2 == lo_q) || (c_s3 > best_q))) begin
			best_q <= c_s3;
			bk_q   <= k_s2;
		end
		if (fin_done) begin
			out_idx_q   <= to_q;
			out_score_q <= c_s3;
			out_bp_q    <= first_q ? '0 : XW'(bk_q);
			out_last_q  <= (CW'(to_q) == n_eff - CW'(1));
		end
	end

	assign result.valid            = out_valid_q;
	assign result.state_index      = out_idx_q;
	assign result.path_score       = out_score_q;
	assign result.best_predecessor = out_bp_q;
	assign result.last_of_column   = out_last_q;

endmodule

[tb/tb_viterbi_trellis_acs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_viterbi_trellis_acs: self-checking testbench of the Viterbi trellis ACS
// Loads the transition and initial tables, then runs emission columns under
// several register settings. A scoreboard predicts every result word from its
// own copy of the tables and score banks and checks the block's words in order.
// ----------------------------------------------------------------------------
typedef struct packed {
	logic [vta_pkg::STATE_W-1:0]        state_index;
	logic signed [vta_pkg::SCORE_W-1:0] path_score;
	logic [vta_pkg::STATE_W-1:0]        best_predecessor;
	logic                               last_of_column;
} lattice_word_t;

class lattice_scoreboard;
	bit                                 log_mode;
	bit                                 forced;
	int unsigned                        n_states;
	logic signed [vta_pkg::SCORE_W-1:0] trans_tab [vta_pkg::MAX_STATES*vta_pkg::MAX_STATES];
	logic signed [vta_pkg::SCORE_W-1:0] init_tab [vta_pkg::MAX_STATES];
	logic signed [vta_pkg::SCORE_W-1:0] banks [2][vta_pkg::MAX_STATES];
	bit                                 bank;
	lattice_word_t                      pending [$];
	int                                 errors;

	function new();
		log_mode = 1;
		forced = 0;
		n_states = 32;
		bank = 0;
		errors = 0;
		foreach (trans_tab[i]) trans_tab[i] = 0;
		foreach (init_tab[i]) init_tab[i] = 0;
		foreach (banks[b, i]) banks[b][i] = 0;
	endfunction

	function void write_reg(vta_pkg::cfg_reg_t idx, logic [vta_pkg::CFG_DAT_W-1:0] d);
		case (idx)
			vta_pkg::REG_USE_LOG: log_mode = d[0];
			vta_pkg::REG_FORCED: forced = d[0];
			vta_pkg::REG_STATES: n_states = (d == 0) ? 1 :
				(d > vta_pkg::MAX_STATES ? vta_pkg::MAX_STATES : d);
			default: ;
		endcase
	endfunction

	function logic signed [vta_pkg::SCORE_W-1:0] clamp(logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function logic signed [vta_pkg::SCORE_W-1:0] merge(logic signed [31:0] a,
			logic signed [31:0] b);
		logic signed [65:0] p;
		if (log_mode) return clamp(66'(a) + 66'(b));
		p = 66'(a) * 66'(b) + (66'sd1 <<< 29);
		return clamp(p >>> 30);  // arithmetic shift floors
	endfunction

	function void note_item(vta_pkg::func_t f, logic [4:0] src, logic [4:0] dst,
			logic signed [31:0] v, logic first);
		lattice_word_t w;
		logic signed [31:0] best, c, score;
		int lo, hi, bk;
		if (f == vta_pkg::FUNC_TRANS) begin
			trans_tab[src*vta_pkg::MAX_STATES + dst] = v;
			return;
		end
		if (f == vta_pkg::FUNC_INIT) begin
			init_tab[dst] = v;
			return;
		end
		if (f != vta_pkg::FUNC_EMIT || dst >= n_states) return;
		bk = 0;
		if (first) begin
			score = merge(init_tab[dst], v);
		end else begin
			lo = forced ? (dst >= 2 ? dst - 2 : 0) : 0;
			hi = forced ? dst : n_states - 1;
			bk = lo;
			best = merge(banks[!bank][lo], trans_tab[lo*vta_pkg::MAX_STATES + dst]);
			for (int k = lo + 1; k <= hi; k++) begin
				c = merge(banks[!bank][k], trans_tab[k*vta_pkg::MAX_STATES + dst]);
				if (c > best) begin
					best = c;
					bk = k;
				end
			end
			score = merge(best, v);
		end
		banks[bank][dst] = score;
		w.state_index = dst;
		w.path_score = score;
		w.best_predecessor = vta_pkg::STATE_W'(bk);
		w.last_of_column = (dst == n_states - 1);
		pending.push_back(w);
		if (dst == n_states - 1) bank = !bank;
	endfunction

	function void check_word(lattice_word_t got);
		lattice_word_t e;
		if (pending.size() == 0) begin
			$error("unexpected result word: state %0d", got.state_index);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.state_index !== e.state_index) begin
			$error("state_index: expected %0d, got %0d", e.state_index, got.state_index);
			errors++;
		end
		if (got.path_score !== e.path_score) begin
			$error("path_score: expected %0d, got %0d", e.path_score, got.path_score);
			errors++;
		end
		if (got.best_predecessor !== e.best_predecessor) begin
			$error("best_predecessor: expected %0d, got %0d", e.best_predecessor,
				got.best_predecessor);
			errors++;
		end
		if (got.last_of_column !== e.last_of_column) begin
			$error("last_of_column: expected %0d, got %0d", e.last_of_column,
				got.last_of_column);
			errors++;
		end
	endfunction
endclass

module tb_viterbi_trellis_acs;
	logic clk = 0;
	logic arst_n = 0;

	vta_in_if  item_ch();
	vta_out_if res_ch();
	vta_cfg_if cfg_ch();

	viterbi_trellis_acs dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(res_ch), .cfg(cfg_ch)
	);

	lattice_scoreboard sb = new();
	int n_cur = 32;
	bit rx_quiet;

	always #5 clk = ~clk;

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// receiver: random stalls unless rx_quiet, sample at rising edge
	always @(negedge clk) res_ch.ready <= rx_quiet ? 1'b1 : (gap_len() == 0);

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_word({res_ch.state_index, res_ch.path_score,
				res_ch.best_predecessor, res_ch.last_of_column});
	end

	// valid stays up after a word so a following word can be sent back to back
	task automatic send(vta_pkg::func_t f, int src, int dst, logic signed [31:0] v,
			bit first, bit nogap = 0);
		int g;
		g = nogap ? 0 : gap_len();
		if (g > 0) begin
			item_ch.valid <= 0;
			repeat (g) @(negedge clk);
		end
		item_ch.valid <= 1;
		item_ch.func <= f;
		item_ch.from_state <= vta_pkg::STATE_W'(src);
		item_ch.to_state <= vta_pkg::STATE_W'(dst);
		item_ch.value <= v;
		item_ch.first_obs <= first;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(f, vta_pkg::STATE_W'(src), vta_pkg::STATE_W'(dst), v, first);
		@(negedge clk);
	endtask

	task automatic write_reg(vta_pkg::cfg_reg_t idx, int d);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= vta_pkg::CFG_DAT_W'(d);
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, vta_pkg::CFG_DAT_W'(d));
		@(negedge clk);
	endtask

	task automatic drain();
		item_ch.valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);  // ignored items may still be in flight
	endtask

	function logic signed [31:0] rand_score(bit log_mode);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom();
		if (r == 1) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		if (log_mode) return -$signed({1'b0, 31'($urandom_range(0, 32'h0fffffff))});
		return $urandom_range(0, 32'h40000000);
	endfunction

	// new setting: tables reloaded for all states in use so no unwritten entry is read
	task automatic phase(bit lg, bit fa, int n, int cols);
		drain();
		write_reg(vta_pkg::REG_USE_LOG, lg);
		write_reg(vta_pkg::REG_FORCED, fa);
		write_reg(vta_pkg::REG_STATES, n);
		cfg_ch.valid <= 0;
		n_cur = (n == 0) ? 1 : (n > 32 ? 32 : n);
		for (int i = 0; i < n_cur; i++) begin
			send(vta_pkg::FUNC_INIT, $urandom_range(0, 31), i, rand_score(lg),
				$urandom_range(0, 1));
			for (int j = 0; j < n_cur; j++)
				send(vta_pkg::FUNC_TRANS, i, j, rand_score(lg), $urandom_range(0, 1), 1);
		end
		for (int c = 0; c < cols; c++) begin
			for (int s = 0; s < n_cur; s++) begin
				if ($urandom_range(0, 19) == 0)
					send(vta_pkg::FUNC_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
						$urandom(), $urandom_range(0, 1));
				if ($urandom_range(0, 29) == 0 && n_cur < 32)
					send(vta_pkg::FUNC_EMIT, 0, $urandom_range(n_cur, 31), $urandom(), 0);
				if ($urandom_range(0, 39) == 0)  // rewrite a transition mid-stream
					send(vta_pkg::FUNC_TRANS, $urandom_range(0, n_cur - 1),
						$urandom_range(0, n_cur - 1), rand_score(lg), 0);
				send(vta_pkg::FUNC_EMIT, $urandom_range(0, 31), s, rand_score(lg), c == 0);
			end
		end
	endtask

	initial begin
		item_ch.valid = 0;
		item_ch.func = vta_pkg::FUNC_NONE;
		item_ch.from_state = 0;
		item_ch.to_state = 0;
		item_ch.value = 0;
		item_ch.first_obs = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = vta_pkg::REG_NONE;
		cfg_ch.data = 0;
		rx_quiet = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes, ignored codes, small and full sizes
		phase(1, 0, 3, 2);
		send(vta_pkg::FUNC_EMIT, 0, 0, 32'sh7fffffff, 1);
		send(vta_pkg::FUNC_EMIT, 0, 1, 32'sh80000000, 1);
		send(vta_pkg::FUNC_EMIT, 0, 2, 0, 1);
		send(vta_pkg::FUNC_EMIT, 31, 5, 32'sh7fffffff, 0);
		send(vta_pkg::FUNC_NONE, 31, 31, 32'shffffffff, 1);
		phase(0, 1, 0, 3);
		phase(0, 0, 63, 1);
		rx_quiet = 1;
		phase(1, 0, 6, 3);
		rx_quiet = 0;
		// random part: mostly small sizes
		for (int p = 0; p < 10; p++)
			phase($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(1, 8),
				$urandom_range(2, 5));
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
